// ----- hw/rtl/align_vector_rotation_matrix_top_defines.svh -----
// Assertion macros shared by the align-vector rotation RTL
`ifndef ALIGN_VECTOR_ROTATION_MATRIX_TOP_DEFINES_SVH
`define ALIGN_VECTOR_ROTATION_MATRIX_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define AVRM_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define AVRM_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AVRM_CHECK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/avrm_pkg.sv -----
// Types and constants for the align-vector rotation matrix block
`timescale 1ns / 1ps
package avrm_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int PROD_W     = 2 * IN_W;
  localparam int V_W        = PROD_W + 1;
  localparam int C_W        = PROD_W + 2;
  localparam int OMC_S_W    = C_W + 1;
  localparam int OMC_W      = PROD_W;
  localparam int SQ_W       = 2 * PROD_W;
  localparam int PP_W       = 2 * V_W;
  localparam int Q_W        = OMC_W;
  localparam int N_W        = SQ_W + OMC_W;
  localparam int VRND_W     = V_W + 1;
  localparam int VRM_W      = VRND_W - FRAC_BITS;
  localparam int VR_W       = VRM_W + 1;
  localparam int QR_W       = Q_W + 1;
  localparam int TM_W       = QR_W - FRAC_BITS;
  localparam int TERM_W     = TM_W + 1;
  localparam int SUM_W      = TERM_W + 3;
  localparam int LANES      = 6;
  localparam int DIV_STAGES = Q_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int ONE  = 1 << FRAC_BITS;

  localparam logic signed [OMC_S_W-1:0] ONE_SQ      = OMC_S_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [SUM_W-1:0]   SUM_ONE     = SUM_W'(ONE);
  localparam logic signed [SUM_W-1:0]   SUM_NEG_ONE = -SUM_W'(ONE);
  localparam logic signed [OUT_W-1:0]   OUT_ONE     = OUT_W'(ONE);

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] a_z;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
    logic                    degenerate;
  } out_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic signed [V_W-1:0] v0;
    logic signed [V_W-1:0] v1;
    logic signed [V_W-1:0] v2;
    logic signed [C_W-1:0] c;
    logic                  degen;
  } cls_t;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic signed [VR_W-1:0] vr0;
    logic signed [VR_W-1:0] vr1;
    logic signed [VR_W-1:0] vr2;
    logic [LANES-1:0]       neg;
    logic                   degen;
  } side_t;

endpackage

// ----- hw/rtl/avrm_fifo.sv -----
// Short queue between the front end and the back end
`timescale 1ns / 1ps
`include "align_vector_rotation_matrix_top_defines.svh"
module avrm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  avrm_pkg::cls_t  wdata,
  output logic            full,
  input  logic            pop,
  output avrm_pkg::cls_t  rdata,
  output logic            empty
);

  avrm_pkg::cls_t                  mem [avrm_pkg::FIFO_DEPTH];
  logic [avrm_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [avrm_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [avrm_pkg::FIFO_CW-1:0]    count;

  assign full  = (count == avrm_pkg::FIFO_CW'(avrm_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AVRM_CHECK(a_fifo_ptr_count, (wr_ptr - rd_ptr) == count[avrm_pkg::FIFO_AW-1:0], "queue pointers and fill count disagree")

endmodule

// ----- hw/rtl/avrm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, six lanes on a shared divisor
`timescale 1ns / 1ps
module avrm_div (
  input  logic                        clk,
  input  logic [avrm_pkg::SQ_W-1:0]   den,
  input  logic [avrm_pkg::N_W-1:0]    num [avrm_pkg::LANES],
  output logic [avrm_pkg::Q_W-1:0]    quo [avrm_pkg::LANES]
);

  // divisor and partial remainders travel with the data; the low word shifts
  // dividend bits out at the top and quotient bits in at the bottom
  logic [avrm_pkg::SQ_W-1:0] d_q [avrm_pkg::DIV_STAGES-1];
  logic [avrm_pkg::SQ_W-1:0] r_q [avrm_pkg::DIV_STAGES-1][avrm_pkg::LANES];
  logic [avrm_pkg::Q_W-1:0]  l_q [avrm_pkg::DIV_STAGES][avrm_pkg::LANES];

  for (genvar s = 0; s < avrm_pkg::DIV_STAGES; s++) begin : g_stage
    logic [avrm_pkg::SQ_W-1:0] d_in;
    logic [avrm_pkg::SQ_W-1:0] r_in [avrm_pkg::LANES];
    logic [avrm_pkg::Q_W-1:0]  l_in [avrm_pkg::LANES];
    logic [avrm_pkg::SQ_W-1:0] r_next [avrm_pkg::LANES];
    logic [avrm_pkg::Q_W-1:0]  l_next [avrm_pkg::LANES];

    if (s == 0) begin : g_head
      always_comb begin
        d_in = den;
        for (int k = 0; k < avrm_pkg::LANES; k++) begin
          r_in[k] = num[k][avrm_pkg::N_W-1:avrm_pkg::Q_W];
          l_in[k] = num[k][avrm_pkg::Q_W-1:0];
        end
      end
    end else begin : g_body
      always_comb begin
        d_in = d_q[s-1];
        for (int k = 0; k < avrm_pkg::LANES; k++) begin
          r_in[k] = r_q[s-1][k];
          l_in[k] = l_q[s-1][k];
        end
      end
    end

    always_comb begin
      logic [avrm_pkg::SQ_W:0] trial;
      logic [avrm_pkg::SQ_W:0] diff;
      logic                    ge;
      for (int k = 0; k < avrm_pkg::LANES; k++) begin
        trial     = {r_in[k], l_in[k][avrm_pkg::Q_W-1]};
        diff      = trial - {1'b0, d_in};
        ge        = (trial >= {1'b0, d_in});
        r_next[k] = ge ? diff[avrm_pkg::SQ_W-1:0] : trial[avrm_pkg::SQ_W-1:0];
        l_next[k] = {l_in[k][avrm_pkg::Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      for (int k = 0; k < avrm_pkg::LANES; k++) begin
        l_q[s][k] <= l_next[k];
      end
    end

    if (s < avrm_pkg::DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        d_q[s] <= d_in;
        for (int k = 0; k < avrm_pkg::LANES; k++) begin
          r_q[s][k] <= r_next[k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < avrm_pkg::LANES; k++) begin
      quo[k] = l_q[avrm_pkg::DIV_STAGES-1][k];
    end
  end

endmodule

// ----- hw/rtl/avrm_front.sv -----
// Front end: takes vector pairs, forms cross and dot products, flags zero cross product
`timescale 1ns / 1ps
`include "align_vector_rotation_matrix_top_defines.svh"
module avrm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  avrm_pkg::in_t   operands,
  output logic            busy,
  output logic            push,
  output avrm_pkg::cls_t  push_data,
  input  logic            full
);

  logic adv;
  logic f1_vld;
  logic f2_vld;
  logic f3_vld;
  avrm_pkg::in_t  f1;
  avrm_pkg::cls_t f3;
  avrm_pkg::cls_t f3_next;
  logic signed [avrm_pkg::PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [avrm_pkg::PROD_W-1:0] d_x, d_y, d_z;

  // hold the whole front end while the queue cannot take the finished item
  assign adv       = !(f3_vld && full);
  assign busy      = !adv;
  assign push      = f3_vld && !full;
  assign push_data = f3;

  always_comb begin
    f3_next.v0 = avrm_pkg::V_W'(p_yz) - avrm_pkg::V_W'(p_zy);
    f3_next.v1 = avrm_pkg::V_W'(p_zx) - avrm_pkg::V_W'(p_xz);
    f3_next.v2 = avrm_pkg::V_W'(p_xy) - avrm_pkg::V_W'(p_yx);
    f3_next.c  = avrm_pkg::C_W'(d_x) + avrm_pkg::C_W'(d_y) + avrm_pkg::C_W'(d_z);
    f3_next.degen = (f3_next.v0 == '0) && (f3_next.v1 == '0) && (f3_next.v2 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= start;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1   <= operands;
      p_yz <= f1.a_y * f1.b_z;
      p_zy <= f1.a_z * f1.b_y;
      p_zx <= f1.a_z * f1.b_x;
      p_xz <= f1.a_x * f1.b_z;
      p_xy <= f1.a_x * f1.b_y;
      p_yx <= f1.a_y * f1.b_x;
      d_x  <= f1.a_x * f1.b_x;
      d_y  <= f1.a_y * f1.b_y;
      d_z  <= f1.a_z * f1.b_z;
      f3   <= f3_next;
    end
  end

  `AVRM_CHECK_NXT(a_front_hold, f3_vld && full, f3_vld && $stable(f3), "front dropped a stalled item")

endmodule

// ----- hw/rtl/avrm_back.sv -----
// Back end: squares, scaling products, long division, rounding and saturation
`timescale 1ns / 1ps
`include "align_vector_rotation_matrix_top_defines.svh"
module avrm_back (
  input  logic            clk,
  input  logic            rst,
  output logic            pop,
  input  avrm_pkg::cls_t  rdata,
  input  logic            empty,
  output logic            strobe,
  output avrm_pkg::out_t  result
);

  // stage 1: item taken from the queue
  logic           b1_vld;
  avrm_pkg::cls_t b1;

  // stage 2: squares, pair products, 1 - c, rounded skew magnitudes
  logic signed [avrm_pkg::PP_W-1:0]    sq_full [3];
  logic signed [avrm_pkg::PP_W-1:0]    pp_full [3];
  logic signed [avrm_pkg::OMC_S_W-1:0] omc_full;
  logic signed [avrm_pkg::OMC_S_W-1:0] omc_abs;
  logic signed [avrm_pkg::V_W-1:0]     vv [3];
  logic [avrm_pkg::V_W-1:0]            vabs [3];
  logic [avrm_pkg::VRND_W-1:0]         vrnd [3];

  logic                         b2_vld;
  logic                         b2_degen;
  logic [avrm_pkg::SQ_W-1:0]    sq [3];
  logic signed [avrm_pkg::PP_W-1:0] pp [3];
  logic                         omc_neg;
  logic [avrm_pkg::OMC_W-1:0]   b2_omc;
  logic [avrm_pkg::VRM_W-1:0]   vrm [3];
  logic [2:0]                   vneg;

  // stage 3: |v|^2, the six numerator magnitudes, signs
  logic signed [avrm_pkg::PP_W-1:0] pp_abs [3];
  avrm_pkg::side_t              b3_side_next;
  logic                         b3_vld;
  logic [avrm_pkg::SQ_W-1:0]    b3_s2;
  logic [avrm_pkg::SQ_W-1:0]    m [avrm_pkg::LANES];
  logic [avrm_pkg::OMC_W-1:0]   b3_omc;
  avrm_pkg::side_t              b3_side;

  // stage 4: partial products of (1 - c) times each numerator
  logic                         b4_vld;
  logic [avrm_pkg::SQ_W-1:0]    pl [avrm_pkg::LANES];
  logic [avrm_pkg::SQ_W-1:0]    ph [avrm_pkg::LANES];
  logic [avrm_pkg::SQ_W-1:0]    b4_s2;
  avrm_pkg::side_t              b4_side;

  // stage 5: full dividends
  logic                         b5_vld;
  logic [avrm_pkg::N_W-1:0]     n [avrm_pkg::LANES];
  logic [avrm_pkg::SQ_W-1:0]    b5_s2;
  avrm_pkg::side_t              b5_side;

  // divider and its side delay line
  logic [avrm_pkg::Q_W-1:0]     q [avrm_pkg::LANES];
  logic                         dvld [avrm_pkg::DIV_STAGES];
  avrm_pkg::side_t              dside [avrm_pkg::DIV_STAGES];

  // stage 6: rounded signed terms
  logic [avrm_pkg::QR_W-1:0]    qr [avrm_pkg::LANES];
  logic signed [avrm_pkg::TERM_W-1:0] term_next [avrm_pkg::LANES];
  logic                         b6_vld;
  logic signed [avrm_pkg::TERM_W-1:0] term [avrm_pkg::LANES];
  avrm_pkg::side_t              b6_side;

  // stage 7: sums and output
  logic signed [avrm_pkg::SUM_W-1:0] e [9];
  avrm_pkg::out_t               result_next;

  function automatic logic signed [avrm_pkg::OUT_W-1:0] sat_entry(
    input logic signed [avrm_pkg::SUM_W-1:0] s
  );
    logic signed [avrm_pkg::SUM_W-1:0] t;
    if (s > avrm_pkg::SUM_ONE) begin
      t = avrm_pkg::SUM_ONE;
    end else if (s < avrm_pkg::SUM_NEG_ONE) begin
      t = avrm_pkg::SUM_NEG_ONE;
    end else begin
      t = s;
    end
    return t[avrm_pkg::OUT_W-1:0];
  endfunction

  // the pipeline never stalls, so drain the queue whenever it has an item
  assign pop = !empty;

  always_comb begin
    vv[0] = b1.v0;
    vv[1] = b1.v1;
    vv[2] = b1.v2;
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = avrm_pkg::PP_W'(vv[i]) * avrm_pkg::PP_W'(vv[i]);
      vabs[i]    = vv[i][avrm_pkg::V_W-1] ? avrm_pkg::V_W'(-vv[i]) : avrm_pkg::V_W'(vv[i]);
      vrnd[i]    = {1'b0, vabs[i]} + avrm_pkg::VRND_W'(avrm_pkg::HALF);
    end
    pp_full[0] = avrm_pkg::PP_W'(b1.v0) * avrm_pkg::PP_W'(b1.v1);
    pp_full[1] = avrm_pkg::PP_W'(b1.v0) * avrm_pkg::PP_W'(b1.v2);
    pp_full[2] = avrm_pkg::PP_W'(b1.v1) * avrm_pkg::PP_W'(b1.v2);
    omc_full   = avrm_pkg::ONE_SQ - avrm_pkg::OMC_S_W'(b1.c);
    omc_abs    = omc_full[avrm_pkg::OMC_S_W-1] ? -omc_full : omc_full;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp_abs[i] = pp[i][avrm_pkg::PP_W-1] ? -pp[i] : pp[i];
    end
    b3_side_next.vr0 = vneg[0] ? -avrm_pkg::VR_W'(vrm[0]) : avrm_pkg::VR_W'(vrm[0]);
    b3_side_next.vr1 = vneg[1] ? -avrm_pkg::VR_W'(vrm[1]) : avrm_pkg::VR_W'(vrm[1]);
    b3_side_next.vr2 = vneg[2] ? -avrm_pkg::VR_W'(vrm[2]) : avrm_pkg::VR_W'(vrm[2]);
    // diagonal numerators carry a minus sign of their own
    b3_side_next.neg[0] = !omc_neg;
    b3_side_next.neg[1] = !omc_neg;
    b3_side_next.neg[2] = !omc_neg;
    b3_side_next.neg[3] = pp[0][avrm_pkg::PP_W-1] ^ omc_neg;
    b3_side_next.neg[4] = pp[1][avrm_pkg::PP_W-1] ^ omc_neg;
    b3_side_next.neg[5] = pp[2][avrm_pkg::PP_W-1] ^ omc_neg;
    b3_side_next.degen  = b2_degen;
  end

  always_comb begin
    for (int k = 0; k < avrm_pkg::LANES; k++) begin
      qr[k] = {1'b0, q[k]} + avrm_pkg::QR_W'(avrm_pkg::HALF);
      term_next[k] = dside[avrm_pkg::DIV_STAGES-1].neg[k]
                   ? -avrm_pkg::TERM_W'(qr[k][avrm_pkg::QR_W-1:avrm_pkg::FRAC_BITS])
                   : avrm_pkg::TERM_W'(qr[k][avrm_pkg::QR_W-1:avrm_pkg::FRAC_BITS]);
    end
  end

  always_comb begin
    e[0] = avrm_pkg::SUM_ONE + avrm_pkg::SUM_W'(term[0]);
    e[1] = -avrm_pkg::SUM_W'(b6_side.vr2) + avrm_pkg::SUM_W'(term[3]);
    e[2] = avrm_pkg::SUM_W'(b6_side.vr1) + avrm_pkg::SUM_W'(term[4]);
    e[3] = avrm_pkg::SUM_W'(b6_side.vr2) + avrm_pkg::SUM_W'(term[3]);
    e[4] = avrm_pkg::SUM_ONE + avrm_pkg::SUM_W'(term[1]);
    e[5] = -avrm_pkg::SUM_W'(b6_side.vr0) + avrm_pkg::SUM_W'(term[5]);
    e[6] = -avrm_pkg::SUM_W'(b6_side.vr1) + avrm_pkg::SUM_W'(term[4]);
    e[7] = avrm_pkg::SUM_W'(b6_side.vr0) + avrm_pkg::SUM_W'(term[5]);
    e[8] = avrm_pkg::SUM_ONE + avrm_pkg::SUM_W'(term[2]);
    if (b6_side.degen) begin
      result_next.r00 = avrm_pkg::OUT_ONE;
      result_next.r01 = '0;
      result_next.r02 = '0;
      result_next.r10 = '0;
      result_next.r11 = avrm_pkg::OUT_ONE;
      result_next.r12 = '0;
      result_next.r20 = '0;
      result_next.r21 = '0;
      result_next.r22 = avrm_pkg::OUT_ONE;
    end else begin
      result_next.r00 = sat_entry(e[0]);
      result_next.r01 = sat_entry(e[1]);
      result_next.r02 = sat_entry(e[2]);
      result_next.r10 = sat_entry(e[3]);
      result_next.r11 = sat_entry(e[4]);
      result_next.r12 = sat_entry(e[5]);
      result_next.r20 = sat_entry(e[6]);
      result_next.r21 = sat_entry(e[7]);
      result_next.r22 = sat_entry(e[8]);
    end
    result_next.degenerate = b6_side.degen;
  end

  avrm_div u_div (
    .clk (clk),
    .den (b5_s2),
    .num (n),
    .quo (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      b3_vld <= 1'b0;
      b4_vld <= 1'b0;
      b5_vld <= 1'b0;
      for (int s = 0; s < avrm_pkg::DIV_STAGES; s++) begin
        dvld[s] <= 1'b0;
      end
      b6_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      b1_vld  <= pop;
      b2_vld  <= b1_vld;
      b3_vld  <= b2_vld;
      b4_vld  <= b3_vld;
      b5_vld  <= b4_vld;
      dvld[0] <= b5_vld;
      for (int s = 1; s < avrm_pkg::DIV_STAGES; s++) begin
        dvld[s] <= dvld[s-1];
      end
      b6_vld <= dvld[avrm_pkg::DIV_STAGES-1];
      strobe <= b6_vld;
    end
  end

  always_ff @(posedge clk) begin
    b1 <= rdata;

    b2_degen <= b1.degen;
    for (int i = 0; i < 3; i++) begin
      sq[i]   <= sq_full[i][avrm_pkg::SQ_W-1:0];
      pp[i]   <= pp_full[i];
      vrm[i]  <= vrnd[i][avrm_pkg::VRND_W-1:avrm_pkg::FRAC_BITS];
      vneg[i] <= vv[i][avrm_pkg::V_W-1];
    end
    omc_neg <= omc_full[avrm_pkg::OMC_S_W-1];
    b2_omc  <= omc_abs[avrm_pkg::OMC_W-1:0];

    b3_s2   <= sq[0] + sq[1] + sq[2];
    m[0]    <= sq[1] + sq[2];
    m[1]    <= sq[0] + sq[2];
    m[2]    <= sq[0] + sq[1];
    m[3]    <= pp_abs[0][avrm_pkg::SQ_W-1:0];
    m[4]    <= pp_abs[1][avrm_pkg::SQ_W-1:0];
    m[5]    <= pp_abs[2][avrm_pkg::SQ_W-1:0];
    b3_omc  <= b2_omc;
    b3_side <= b3_side_next;

    for (int k = 0; k < avrm_pkg::LANES; k++) begin
      pl[k] <= avrm_pkg::SQ_W'(b3_omc) * avrm_pkg::SQ_W'(m[k][avrm_pkg::OMC_W-1:0]);
      ph[k] <= avrm_pkg::SQ_W'(b3_omc) *
               avrm_pkg::SQ_W'(m[k][avrm_pkg::SQ_W-1:avrm_pkg::OMC_W]);
    end
    b4_s2   <= b3_s2;
    b4_side <= b3_side;

    for (int k = 0; k < avrm_pkg::LANES; k++) begin
      n[k] <= {ph[k], {avrm_pkg::OMC_W{1'b0}}} + avrm_pkg::N_W'(pl[k]);
    end
    b5_s2   <= b4_s2;
    b5_side <= b4_side;

    dside[0] <= b5_side;
    for (int s = 1; s < avrm_pkg::DIV_STAGES; s++) begin
      dside[s] <= dside[s-1];
    end

    for (int k = 0; k < avrm_pkg::LANES; k++) begin
      term[k] <= term_next[k];
    end
    b6_side <= dside[avrm_pkg::DIV_STAGES-1];

    result <= result_next;
  end

  `AVRM_CHECK_IMP(a_div_align, b6_vld, $past(b5_vld, avrm_pkg::DIV_STAGES + 1), "quotient not aligned with its item")
  `AVRM_CHECK_IMP(a_degen_ident, strobe && result.degenerate, result.r00 == avrm_pkg::OUT_ONE && result.r11 == avrm_pkg::OUT_ONE && result.r22 == avrm_pkg::OUT_ONE && result.r01 == '0, "degenerate result is not the identity")

endmodule

// ----- hw/rtl/align_vector_rotation_matrix_top.sv -----
// A result strobes after its vector pair has passed the front end, the queue, the back-end stages and the divider.
// Throughput: one pair per cycle while busy is low; the 32-stage divider and the multiplier stages are pipelined.
// busy rises only when the front-to-back queue is full, which a non-stalling receiver never causes.
// Reset (rst, synchronous, active high) clears all valid bits and the queue; nothing is swept.
`timescale 1ns / 1ps
module align_vector_rotation_matrix_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  avrm_pkg::in_t   operands,
  output logic            strobe,
  output avrm_pkg::out_t  result
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  avrm_pkg::cls_t push_data;
  avrm_pkg::cls_t rdata;

  avrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operands  (operands),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  avrm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  avrm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .pop    (pop),
    .rdata  (rdata),
    .empty  (empty),
    .strobe (strobe),
    .result (result)
  );

endmodule
